@@ src/line_rasterizer_stepper_top_assert.svh @@
// Assertion macros for the line rasterizer stepper checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LINE_RASTERIZER_STEPPER_TOP_ASSERT_SVH
`define LINE_RASTERIZER_STEPPER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define LRS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lrs_pkg.sv @@
// Shared types, widths and codes for the line rasterizer stepper.
// No dependencies; every other module file imports this package.
package lrs_pkg;

    localparam int COORD_BITS  = 16;
    localparam int OFFSET_BITS = 28;

    localparam int DIM_W      = 13;
    localparam int BPP_W      = 4;
    localparam int PITCH_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int XPROD_W = COORD_BITS + BPP_W;
    localparam int YPROD_W = COORD_BITS + PITCH_W;
    localparam int SUM_W   = ((YPROD_W > XPROD_W) ? YPROD_W : XPROD_W) + 1;
    localparam int WIDE_W  = (SUM_W > OFFSET_BITS) ? SUM_W : OFFSET_BITS;
    localparam int CMP_W   = COORD_BITS + DIM_W;

    localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(1024);
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(768);
    localparam logic [BPP_W-1:0]   BPP_RESET    = BPP_W'(4);
    localparam logic [PITCH_W-1:0] PITCH_RESET  = PITCH_W'(4096);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT,
        REG_BYTES_PER_PIXEL,
        REG_LINE_PITCH
    } lrs_reg_t;

    typedef struct packed {
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic [PITCH_W-1:0] line_pitch;
    } lrs_cfg_t;

    // Input item
    typedef struct packed {
        logic                         opcode;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } lrs_cmd_t;

    // Result item
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         in_bounds;
        logic [OFFSET_BITS-1:0]       pixel_offset;
        logic [COORD_BITS-1:0]        step_index;
        logic [COORD_BITS-1:0]        span;
        logic                         ends_swapped;
        logic                         last_pixel;
    } lrs_pix_t;

    // Classified item as held in the queue between front and back
    typedef struct packed {
        logic                         opcode;
        logic signed [COORD_BITS-1:0] major_start;
        logic signed [COORD_BITS-1:0] major_end;
        logic signed [COORD_BITS-1:0] minor_start;
        logic [COORD_BITS-1:0]        major_delta;
        logic [COORD_BITS-1:0]        minor_delta;
        logic [COORD_BITS-1:0]        delta_gap;
        logic                         minor_dir_down;
        logic                         steep;
        logic                         swapped;
    } lrs_entry_t;

endpackage

@@ src/lrs_front.sv @@
// Front end: accepts input items and classifies line endpoints.
// Depends on lrs_pkg; feeds lrs_queue.
module lrs_front (
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  lrs_pkg::lrs_cmd_t cmd,
    input  logic              q_full,
    output logic              push,
    output lrs_pkg::lrs_entry_t entry
);
    import lrs_pkg::*;

    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic signed [COORD_BITS:0]   dx_s, dy_s;
    logic [COORD_BITS:0]          dx_neg, dy_neg;
    logic [COORD_BITS-1:0]        dx, dy;
    logic                         steep, swapped, x_gt, y_gt;
    logic signed [COORD_BITS-1:0] maj_a, maj_b, min_a, min_b;
    logic signed [COORD_BITS-1:0] major_start, major_end, minor_start, minor_end;
    logic [COORD_BITS-1:0]        major_delta, minor_delta;

    // Accept whenever the queue has room
    assign cmd_stall = q_full;
    assign push      = cmd_valid && !q_full;

    assign ax = cmd.start_x;
    assign ay = cmd.start_y;
    assign bx = cmd.end_x;
    assign by = cmd.end_y;

    // Absolute axis deltas
    assign dx_s   = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
    assign dy_s   = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
    assign dx_neg = -dx_s;
    assign dy_neg = -dy_s;
    assign dx     = dx_s[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx_s[COORD_BITS-1:0];
    assign dy     = dy_s[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy_s[COORD_BITS-1:0];

    // Pick the major axis and order endpoints along it
    assign steep   = dy > dx;
    assign x_gt    = ax > bx;
    assign y_gt    = ay > by;
    assign swapped = steep ? y_gt : x_gt;

    assign maj_a = steep ? ay : ax;
    assign maj_b = steep ? by : bx;
    assign min_a = steep ? ax : ay;
    assign min_b = steep ? bx : by;

    assign major_start = swapped ? maj_b : maj_a;
    assign major_end   = swapped ? maj_a : maj_b;
    assign minor_start = swapped ? min_b : min_a;
    assign minor_end   = swapped ? min_a : min_b;

    assign major_delta = steep ? dy : dx;
    assign minor_delta = steep ? dx : dy;

    // Pack the classified item
    always_comb
    begin
        entry.opcode         = cmd.opcode;
        entry.major_start    = major_start;
        entry.major_end      = major_end;
        entry.minor_start    = minor_start;
        entry.major_delta    = major_delta;
        entry.minor_delta    = minor_delta;
        entry.delta_gap      = major_delta - minor_delta;
        entry.minor_dir_down = !(minor_start < minor_end);
        entry.steep          = steep;
        entry.swapped        = swapped;
    end

endmodule

@@ src/lrs_queue.sv @@
// Short FIFO between the front end and the stepping back end.
// Depends on lrs_pkg for the entry type and depth.
module lrs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lrs_pkg::lrs_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output lrs_pkg::lrs_entry_t pop_entry,
    output logic                empty
);
    import lrs_pkg::*;

    lrs_entry_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full      = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign pop_entry = slots_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ src/lrs_back.sv @@
// Back end: Bresenham stepper plus a clip, multiply and offset pipeline.
// Depends on lrs_pkg; pulls classified items from lrs_queue.
module lrs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lrs_pkg::lrs_cfg_t   cfg,
    input  logic                q_empty,
    input  lrs_pkg::lrs_entry_t q_entry,
    output logic                q_pop,
    output logic                pix_valid,
    input  logic                pix_stall,
    output lrs_pkg::lrs_pix_t   pix
);
    import lrs_pkg::*;

    // Line state
    logic signed [COORD_BITS:0]   major_pos_reg, major_pos_next;
    logic signed [COORD_BITS:0]   minor_pos_reg, minor_pos_next;
    logic signed [COORD_BITS:0]   major_start_reg, major_start_next;
    logic signed [COORD_BITS:0]   major_end_reg, major_end_next;
    logic signed [COORD_BITS+1:0] error_reg, error_next;
    logic [COORD_BITS-1:0]        major_delta_reg, major_delta_next;
    logic [COORD_BITS-1:0]        minor_delta_reg, minor_delta_next;
    logic [COORD_BITS-1:0]        delta_gap_reg, delta_gap_next;
    logic                         dir_down_reg, dir_down_next;
    logic                         steep_reg, steep_next;
    logic                         swapped_reg, swapped_next;
    logic                         active_reg, active_next;

    // Pipeline stages
    logic                         s1_valid_reg, s2_valid_reg, pix_valid_reg;
    logic signed [COORD_BITS:0]   s1_x_reg, s1_y_reg;
    logic [COORD_BITS-1:0]        s1_step_reg, s1_span_reg;
    logic                         s1_swapped_reg, s1_last_reg;
    logic signed [COORD_BITS-1:0] s2_x_reg, s2_y_reg;
    logic [COORD_BITS-1:0]        s2_step_reg, s2_span_reg;
    logic                         s2_swapped_reg, s2_last_reg, s2_inb_reg;
    logic [XPROD_W-1:0]           s2_xprod_reg;
    logic [YPROD_W-1:0]           s2_yprod_reg;
    lrs_pix_t                     pix_reg;

    logic                         out_en, s2_en, s1_en;
    logic                         take_load, take_step, last;
    logic signed [COORD_BITS+1:0] err_sub, err_alt;
    logic signed [COORD_BITS:0]   minor_inc, step_diff, cur_x, cur_y;
    logic [CMP_W-1:0]             x_cmp, y_cmp, w_cmp, h_cmp;
    logic                         inb;
    logic [WIDE_W-1:0]            offset_sum;

    // Stall chain from the output register back to the queue
    assign out_en    = !pix_valid_reg || !pix_stall;
    assign s2_en     = !s2_valid_reg || out_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign q_pop     = !q_empty && s1_en;
    assign take_load = q_pop && (q_entry.opcode == OP_LOAD);
    assign take_step = q_pop && (q_entry.opcode == OP_STEP) && active_reg;

    // Step arithmetic: both error outcomes in parallel, sign picks one
    assign last      = major_pos_reg >= major_end_reg;
    assign err_sub   = error_reg - {2'b00, minor_delta_reg};
    assign err_alt   = error_reg + {2'b00, delta_gap_reg};
    assign minor_inc = dir_down_reg ? {(COORD_BITS + 1){1'b1}} : (COORD_BITS + 1)'(1);
    assign step_diff = major_pos_reg - major_start_reg;
    assign cur_x     = steep_reg ? minor_pos_reg : major_pos_reg;
    assign cur_y     = steep_reg ? major_pos_reg : minor_pos_reg;

    // Load a new line or advance the current one
    always_comb
    begin
        major_pos_next   = major_pos_reg;
        minor_pos_next   = minor_pos_reg;
        major_start_next = major_start_reg;
        major_end_next   = major_end_reg;
        error_next       = error_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        delta_gap_next   = delta_gap_reg;
        dir_down_next    = dir_down_reg;
        steep_next       = steep_reg;
        swapped_next     = swapped_reg;
        active_next      = active_reg;
        if (take_load)
        begin
            major_pos_next   = {q_entry.major_start[COORD_BITS-1], q_entry.major_start};
            major_start_next = {q_entry.major_start[COORD_BITS-1], q_entry.major_start};
            major_end_next   = {q_entry.major_end[COORD_BITS-1], q_entry.major_end};
            minor_pos_next   = {q_entry.minor_start[COORD_BITS-1], q_entry.minor_start};
            error_next       = {3'b000, q_entry.major_delta[COORD_BITS-1:1]};
            major_delta_next = q_entry.major_delta;
            minor_delta_next = q_entry.minor_delta;
            delta_gap_next   = q_entry.delta_gap;
            dir_down_next    = q_entry.minor_dir_down;
            steep_next       = q_entry.steep;
            swapped_next     = q_entry.swapped;
            active_next      = 1'b1;
        end
        else if (take_step)
        begin
            if (err_sub[COORD_BITS+1])
            begin
                minor_pos_next = minor_pos_reg + minor_inc;
                error_next     = err_alt;
            end
            else
            begin
                error_next = err_sub;
            end
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + (COORD_BITS + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_pos_reg   <= '0;
            minor_pos_reg   <= '0;
            major_start_reg <= '0;
            major_end_reg   <= '0;
            error_reg       <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            delta_gap_reg   <= '0;
            dir_down_reg    <= 1'b0;
            steep_reg       <= 1'b0;
            swapped_reg     <= 1'b0;
            active_reg      <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            pix_valid_reg   <= 1'b0;
        end
        else
        begin
            major_pos_reg   <= major_pos_next;
            minor_pos_reg   <= minor_pos_next;
            major_start_reg <= major_start_next;
            major_end_reg   <= major_end_next;
            error_reg       <= error_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            delta_gap_reg   <= delta_gap_next;
            dir_down_reg    <= dir_down_next;
            steep_reg       <= steep_next;
            swapped_reg     <= swapped_next;
            active_reg      <= active_next;
            if (s1_en)
            begin
                s1_valid_reg <= take_step;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en)
            begin
                pix_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: capture the current pixel of the line
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_x_reg       <= cur_x;
            s1_y_reg       <= cur_y;
            s1_step_reg    <= step_diff[COORD_BITS-1:0];
            s1_span_reg    <= major_delta_reg;
            s1_swapped_reg <= swapped_reg;
            s1_last_reg    <= last;
        end
    end

    // Stage 2: clip test and the two offset products
    assign x_cmp = {{DIM_W{1'b0}}, s1_x_reg[COORD_BITS-1:0]};
    assign y_cmp = {{DIM_W{1'b0}}, s1_y_reg[COORD_BITS-1:0]};
    assign w_cmp = {{COORD_BITS{1'b0}}, cfg.screen_width};
    assign h_cmp = {{COORD_BITS{1'b0}}, cfg.screen_height};
    assign inb   = !s1_x_reg[COORD_BITS] && !s1_y_reg[COORD_BITS]
                   && (x_cmp < w_cmp) && (y_cmp < h_cmp);

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_x_reg       <= s1_x_reg[COORD_BITS-1:0];
            s2_y_reg       <= s1_y_reg[COORD_BITS-1:0];
            s2_inb_reg     <= inb;
            s2_xprod_reg   <= XPROD_W'(s1_x_reg[COORD_BITS-1:0]) * XPROD_W'(cfg.bytes_per_pixel);
            s2_yprod_reg   <= YPROD_W'(s1_y_reg[COORD_BITS-1:0]) * YPROD_W'(cfg.line_pitch);
            s2_step_reg    <= s1_step_reg;
            s2_span_reg    <= s1_span_reg;
            s2_swapped_reg <= s1_swapped_reg;
            s2_last_reg    <= s1_last_reg;
        end
    end

    // Stage 3: sum into the output register, zero the offset when clipped
    assign offset_sum = WIDE_W'(s2_xprod_reg) + WIDE_W'(s2_yprod_reg);

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            pix_reg.pixel_x      <= s2_x_reg;
            pix_reg.pixel_y      <= s2_y_reg;
            pix_reg.in_bounds    <= s2_inb_reg;
            pix_reg.pixel_offset <= s2_inb_reg ? offset_sum[OFFSET_BITS-1:0] : '0;
            pix_reg.step_index   <= s2_step_reg;
            pix_reg.span         <= s2_span_reg;
            pix_reg.ends_swapped <= s2_swapped_reg;
            pix_reg.last_pixel   <= s2_last_reg;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule

@@ src/line_rasterizer_stepper_top.sv @@
// A step item's pixel passes stage 1, stage 2 and the output register once accepted.
// One item per cycle unless stalled; the stepper's add and compare loop sets the pace.
// A load item is taken by the stepper and gives no pixel.
// The 4-entry queue absorbs output stalls before the command side stalls.
// Reset: registers return to 1024 x 768, 4 bytes/pixel, pitch 4096; no line active.
// Top level of the line rasterizer stepper; depends on lrs_pkg and submodules.
module line_rasterizer_stepper_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  lrs_pkg::lrs_cmd_t               cmd,
    output logic                            pix_valid,
    input  logic                            pix_stall,
    output lrs_pkg::lrs_pix_t               pix,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lrs_pkg::*;

    lrs_cfg_t   cfg_reg, cfg_next;
    logic       q_full, q_empty, q_push, q_pop;
    lrs_entry_t push_entry, pop_entry;

    // Register writes are always accepted
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (lrs_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:    cfg_next.screen_width    = cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT:   cfg_next.screen_height   = cfg_data[DIM_W-1:0];
                REG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = cfg_data[BPP_W-1:0];
                REG_LINE_PITCH:      cfg_next.line_pitch      = cfg_data[PITCH_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width    <= WIDTH_RESET;
            cfg_reg.screen_height   <= HEIGHT_RESET;
            cfg_reg.bytes_per_pixel <= BPP_RESET;
            cfg_reg.line_pitch      <= PITCH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lrs_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_full),
        .push      (q_push),
        .entry     (push_entry)
    );

    lrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    lrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

endmodule

@@ src/lrs_checker.sv @@
// Port-level checks for the line rasterizer stepper, bound to the top level.
// Depends on lrs_pkg and line_rasterizer_stepper_top_assert.svh.
`include "line_rasterizer_stepper_top_assert.svh"

module lrs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pix_valid,
    input logic              pix_stall,
    input lrs_pkg::lrs_pix_t pix
);
    import lrs_pkg::*;

    // Hold a stalled pixel unchanged
    `LRS_ASSERT_NEXT(a_pix_hold, pix_valid && pix_stall,
                     pix_valid && $stable(pix), "stalled pixel changed")

    // Drop the offset of a clipped pixel to zero
    `LRS_ASSERT_SAME(a_clip_offset, pix_valid && !pix.in_bounds,
                     pix.pixel_offset == '0, "clipped pixel has offset")

    // Visible pixels never carry negative coordinates
    `LRS_ASSERT_SAME(a_bounds_sign, pix_valid && pix.in_bounds,
                     !pix.pixel_x[COORD_BITS-1] && !pix.pixel_y[COORD_BITS-1],
                     "visible pixel is negative")

    // The final pixel sits at the far end of the span
    `LRS_ASSERT_SAME(a_last_span, pix_valid && pix.last_pixel,
                     pix.step_index == pix.span, "last pixel off the span end")

endmodule

bind line_rasterizer_stepper_top lrs_checker u_lrs_checker (.*);
